// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define VNEG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define VNEG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/vneg_pkg.sv =====
package vneg_pkg;

  // Field widths.
  localparam int VER_W   = 32;
  localparam int OP_W    = 2;
  localparam int PHASE_W = 2;
  localparam int CNT_W   = 3;
  localparam int IDX_W   = 3;

  // Number of supported version registers in the register map.
  localparam int VER_REGS = 4;

  // Negotiation phase codes.
  localparam logic [PHASE_W-1:0] PHASE_INITIAL   = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_REACTED   = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_CONFIRMED = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_ERROR     = 2'd3;

  // Item kinds.
  localparam logic [OP_W-1:0] OP_OFFER   = 2'd0;
  localparam logic [OP_W-1:0] OP_AVAIL   = 2'd1;
  localparam logic [OP_W-1:0] OP_CONFIRM = 2'd2;

  // Register indexes.
  localparam logic [IDX_W-1:0] CFG_COUNT = 3'd0;
  localparam logic [IDX_W-1:0] CFG_VER0  = 3'd1;

  // One input item as held in the input register.
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [VER_W-1:0] version_value;
    logic [VER_W-1:0] original_version;
    logic [VER_W-1:0] chosen_version;
    logic [VER_W-1:0] in_use_version;
    logic             last_element;
    logic             list_empty;
  } vneg_item_t;

  // One result item.
  typedef struct packed {
    logic               verdict_valid;
    logic               accepted;
    logic [VER_W-1:0]   picked_version;
    logic [PHASE_W-1:0] phase;
    logic [VER_W-1:0]   negotiated_version;
  } vneg_result_t;

endpackage

// ===== sv/vneg_match.sv =====
module vneg_match #(
  parameter int NREG = 4
) (
  input  logic [vneg_pkg::CNT_W-1:0]           supported_count,
  input  logic [NREG-1:0][vneg_pkg::VER_W-1:0] supported_versions,
  input  logic [vneg_pkg::VER_W-1:0]           version_value,
  output logic                                 hit
);

  // Parallel compare against every register that the count enables.
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < NREG; i++) begin
      if ((supported_count > vneg_pkg::CNT_W'(i)) &&
          (supported_versions[i] == version_value)) begin
        hit = 1'b1;
      end
    end
  end

endmodule

// ===== sv/vneg_core.sv =====
module vneg_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  vneg_pkg::vneg_item_t   item,
  input  logic                   supported_hit,
  output vneg_pkg::vneg_result_t res
);

  logic [vneg_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [vneg_pkg::VER_W-1:0]   negotiated_r, negotiated_nxt;
  logic                         reacted_r, reacted_nxt;
  logic                         offer_orig_r, offer_orig_nxt;
  logic                         cand_found_r, cand_found_nxt;
  logic [vneg_pkg::VER_W-1:0]   cand_ver_r, cand_ver_nxt;
  logic                         avail_chosen_r, avail_chosen_nxt;

  logic orig_seen;
  logic cand_now;
  logic chosen_seen;

  // Element flags folded with what the list has shown so far.
  assign orig_seen   = offer_orig_r | (item.version_value == item.original_version);
  assign cand_now    = cand_found_r |
                       ((item.version_value != item.original_version) & supported_hit);
  assign chosen_seen = avail_chosen_r | (item.version_value == item.chosen_version);

  // Verdict and next state for the item in the input register.
  always_comb begin
    phase_nxt        = phase_r;
    negotiated_nxt   = negotiated_r;
    reacted_nxt      = reacted_r;
    offer_orig_nxt   = offer_orig_r;
    cand_found_nxt   = cand_found_r;
    cand_ver_nxt     = cand_ver_r;
    avail_chosen_nxt = avail_chosen_r;
    res.verdict_valid = 1'b0;
    res.accepted      = 1'b0;
    res.picked_version = '0;

    case (item.op)
      vneg_pkg::OP_OFFER: begin
        if (item.list_empty) begin
          offer_orig_nxt = 1'b0;
          cand_found_nxt = 1'b0;
          res.verdict_valid = 1'b1;
        end else begin
          offer_orig_nxt = orig_seen;
          cand_found_nxt = cand_now;
          if (!cand_found_r && cand_now) begin
            cand_ver_nxt = item.version_value;
          end
          if (item.last_element) begin
            res.verdict_valid = 1'b1;
            if (!reacted_r && !orig_seen && cand_now) begin
              res.accepted = 1'b1;
              res.picked_version = cand_found_r ? cand_ver_r : item.version_value;
              reacted_nxt = 1'b1;
              phase_nxt = vneg_pkg::PHASE_REACTED;
            end
            offer_orig_nxt = 1'b0;
            cand_found_nxt = 1'b0;
          end
        end
      end
      vneg_pkg::OP_AVAIL: begin
        if (item.list_empty) begin
          avail_chosen_nxt = 1'b0;
          res.verdict_valid = 1'b1;
          phase_nxt = vneg_pkg::PHASE_ERROR;
        end else begin
          avail_chosen_nxt = chosen_seen;
          if (item.last_element) begin
            res.verdict_valid = 1'b1;
            if ((item.chosen_version == item.in_use_version) && chosen_seen) begin
              res.accepted = 1'b1;
            end else begin
              phase_nxt = vneg_pkg::PHASE_ERROR;
            end
            avail_chosen_nxt = 1'b0;
          end
        end
      end
      vneg_pkg::OP_CONFIRM: begin
        res.verdict_valid = 1'b1;
        if (phase_r != vneg_pkg::PHASE_ERROR) begin
          phase_nxt = vneg_pkg::PHASE_CONFIRMED;
          negotiated_nxt = item.version_value;
          res.accepted = 1'b1;
        end
      end
      default: begin
      end
    endcase

    res.phase = phase_nxt;
    res.negotiated_version = negotiated_nxt;
  end

  // Session state advances when the item moves to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= vneg_pkg::PHASE_INITIAL;
      negotiated_r   <= '0;
      reacted_r      <= 1'b0;
      offer_orig_r   <= 1'b0;
      cand_found_r   <= 1'b0;
      avail_chosen_r <= 1'b0;
    end else if (en) begin
      phase_r        <= phase_nxt;
      negotiated_r   <= negotiated_nxt;
      reacted_r      <= reacted_nxt;
      offer_orig_r   <= offer_orig_nxt;
      cand_found_r   <= cand_found_nxt;
      avail_chosen_r <= avail_chosen_nxt;
    end
  end

  // The candidate is only read while its found flag is set.
  always_ff @(posedge clk) begin
    if (en) begin
      cand_ver_r <= cand_ver_nxt;
    end
  end

endmodule

// ===== sv/transport_version_negotiation.sv =====
// Transport version negotiation engine.
// Input channel in_*: one word per list element or confirm. tuser carries the
// item kind and the empty-list flag, tlast marks the final list element.
// Kind 0 streams an offered list, kind 1 an Available list, kind 2 confirms.
// Output channel out_*: exactly one word per input word, in order. tuser says
// whether the word is a verdict; tdata carries accepted, the picked version,
// the phase after the word and the negotiated version.
// Configuration channel cfg_*: index 0 is the supported count, indexes 1 to 4
// the supported versions; write only while no word is in flight.
// An accepted word is first held in the input register, then the verdict logic
// and the state update load the result register. The block takes one word per
// cycle while out_tready is high; the session state sits in one register loop.
// When out_tready is low the result word holds and the input register keeps
// one more word; in_tready drops once both are full.
// Synchronous active-low reset clears the session state to the initial phase,
// the configuration registers to zero and both pipeline registers to empty.
module transport_version_negotiation #(
  parameter int MAX_SUPPORTED = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  // Configuration write channel.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  // Input channel.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // version_value, original_version, chosen_version, in_use_version
  input  logic [2:0]   in_tuser,  // op[1:0], list_empty
  input  logic         in_tlast,  // last_element
  // Output channel.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata, // accepted, picked_version, phase, negotiated_version, zero fill
  output logic [0:0]   out_tuser  // verdict_valid
);

  localparam int NREG = (MAX_SUPPORTED < vneg_pkg::VER_REGS) ?
                        MAX_SUPPORTED : vneg_pkg::VER_REGS;

  logic [vneg_pkg::CNT_W-1:0]           sup_count_r;
  logic [NREG-1:0][vneg_pkg::VER_W-1:0] sup_ver_r;

  logic                   in_v_r;
  vneg_pkg::vneg_item_t   in_item_r;
  logic                   out_v_r;
  vneg_pkg::vneg_result_t out_res_r;
  vneg_pkg::vneg_result_t res;
  logic                   hit;
  logic                   advance;
  logic                   in_take;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sup_count_r <= '0;
      sup_ver_r   <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == vneg_pkg::CFG_COUNT) begin
        sup_count_r <= cfg_data[vneg_pkg::CNT_W-1:0];
      end
      for (int i = 0; i < NREG; i++) begin
        if (cfg_index == (vneg_pkg::CFG_VER0 + vneg_pkg::IDX_W'(i))) begin
          sup_ver_r[i] <= cfg_data;
        end
      end
    end
  end

  // Pipeline handshake: the input word moves on when the result slot frees.
  assign advance   = in_v_r & (~out_v_r | out_tready);
  assign in_tready = ~in_v_r | advance;
  assign in_take   = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.op               <= in_tuser[1:0];
      in_item_r.version_value    <= in_tdata[31:0];
      in_item_r.original_version <= in_tdata[63:32];
      in_item_r.chosen_version   <= in_tdata[95:64];
      in_item_r.in_use_version   <= in_tdata[127:96];
      in_item_r.last_element     <= in_tlast;
      in_item_r.list_empty       <= in_tuser[2];
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  vneg_match #(
    .NREG(NREG)
  ) u_match (
    .supported_count   (sup_count_r),
    .supported_versions(sup_ver_r),
    .version_value     (in_item_r.version_value),
    .hit               (hit)
  );

  vneg_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (advance),
    .item         (in_item_r),
    .supported_hit(hit),
    .res          (res)
  );

  // Output packing.
  assign out_tvalid = out_v_r;
  assign out_tuser  = out_res_r.verdict_valid;
  assign out_tdata  = {5'd0, out_res_r.negotiated_version, out_res_r.phase,
                       out_res_r.picked_version, out_res_r.accepted};

endmodule

// ===== sv/vneg_checker.sv =====
`include "assert_macros.svh"

module vneg_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [71:0]  out_tdata,
  input logic [0:0]   out_tuser
);

  // A held result word keeps its contents.
  `VNEG_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result word changed while stalled")

  // Reset empties the result register.
  `VNEG_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid, "result word present after reset")

  // Acceptance is only reported on a verdict.
  `VNEG_ASSERT(a_acc_verdict, out_tvalid && out_tdata[0] |-> out_tuser[0], "accepted without a verdict")

  // A picked version appears only with an accepted verdict.
  `VNEG_ASSERT(a_pick_acc, out_tvalid && (out_tdata[32:1] != 32'd0) |-> out_tdata[0] && out_tuser[0], "picked version without acceptance")

endmodule

bind transport_version_negotiation vneg_checker u_vneg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
